// ===== sv/u8e_pkg.sv =====
// Package for the UTF-8 encoder with byte budget.
// Holds the shared types, register indexes and encoding constants; no dependencies.
package u8e_pkg;

    localparam int CP_W        = 21;
    localparam int BUDGET_CFG_W = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_BUDGET  = 4'd1;

    localparam logic [CP_W-1:0] MAX_LEN1 = 21'h00007F;
    localparam logic [CP_W-1:0] MAX_LEN2 = 21'h0007FF;
    localparam logic [CP_W-1:0] MAX_LEN3 = 21'h00FFFF;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;
    localparam logic [5:0] SIX_ONES = 6'h3F;

    typedef struct packed {
        logic                    limit_enable;
        logic [BUDGET_CFG_W-1:0] byte_budget;
    } u8e_cfg_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } u8e_entry_t;

    typedef struct packed {
        logic halted;
        logic push;
    } u8e_front_stat_t;

endpackage

// ===== sv/u8e_ifs.sv =====
// Handshake channel interfaces for the UTF-8 encoder.
// Depends on u8e_pkg for field widths.
interface u8e_char_if;
    logic                      valid;
    logic                      ready;
    logic [u8e_pkg::CP_W-1:0]  code_point;
    logic                      string_start;
    modport source (output valid, code_point, string_start, input ready);
    modport sink (input valid, code_point, string_start, output ready);
endinterface

interface u8e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       char_last;
    modport source (output valid, out_byte, char_last, input ready);
    modport sink (input valid, out_byte, char_last, output ready);
endinterface

interface u8e_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [u8e_pkg::CFG_IDX_W-1:0]    index;
    logic [u8e_pkg::BUDGET_CFG_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/u8e_front.sv =====
// Front end: accepts characters, applies the string budget and builds the byte entries.
// Depends on u8e_pkg.
module u8e_front #(
    parameter int BUDGET_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  u8e_pkg::u8e_cfg_t            cfg,
    input  logic                         in_valid,
    input  logic [u8e_pkg::CP_W-1:0]     code_point,
    input  logic                         string_start,
    input  logic                         q_full,
    output logic                         in_ready,
    output u8e_pkg::u8e_entry_t          push_entry,
    output u8e_pkg::u8e_front_stat_t     stat
);

    localparam int EXT_W = (BUDGET_WIDTH > u8e_pkg::BUDGET_CFG_W) ?
                           BUDGET_WIDTH : u8e_pkg::BUDGET_CFG_W;

    logic [BUDGET_WIDTH-1:0] left_reg, left_next, left_eff, budget_masked;
    logic                    halted_reg, halted_next, halted_eff;
    logic [EXT_W-1:0]        budget_ext;
    logic [2:0]              len;
    logic                    accept;
    logic [5:0]              s0, s1, s2;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign budget_ext    = EXT_W'(cfg.byte_budget);
    assign budget_masked = budget_ext[BUDGET_WIDTH-1:0];
    assign left_eff      = string_start ? budget_masked : left_reg;
    assign halted_eff    = string_start ? 1'b0 : halted_reg;

    assign s0 = code_point[5:0] & u8e_pkg::SIX_ONES;
    assign s1 = code_point[11:6];
    assign s2 = code_point[17:12];

    always_comb
    begin
        if (code_point <= u8e_pkg::MAX_LEN1)
        begin
            len = 3'd1;
        end
        else if (code_point <= u8e_pkg::MAX_LEN2)
        begin
            len = 3'd2;
        end
        else if (code_point <= u8e_pkg::MAX_LEN3)
        begin
            len = 3'd3;
        end
        else
        begin
            len = 3'd4;
        end
    end

    always_comb
    begin
        push_entry.bytes    = '0;
        push_entry.last_idx = 2'(len - 3'd1);
        unique case (len)
            3'd1:
            begin
                push_entry.bytes[0] = code_point[7:0];
            end
            3'd2:
            begin
                push_entry.bytes[0] = u8e_pkg::LEAD2 | {3'b000, code_point[10:6]};
                push_entry.bytes[1] = u8e_pkg::CONT | {2'b00, s0};
            end
            3'd3:
            begin
                push_entry.bytes[0] = u8e_pkg::LEAD3 | {4'h0, code_point[15:12]};
                push_entry.bytes[1] = u8e_pkg::CONT | {2'b00, s1};
                push_entry.bytes[2] = u8e_pkg::CONT | {2'b00, s0};
            end
            default:
            begin
                push_entry.bytes[0] = u8e_pkg::LEAD4 | {5'h00, code_point[20:18]};
                push_entry.bytes[1] = u8e_pkg::CONT | {2'b00, s2};
                push_entry.bytes[2] = u8e_pkg::CONT | {2'b00, s1};
                push_entry.bytes[3] = u8e_pkg::CONT | {2'b00, s0};
            end
        endcase
    end

    always_comb
    begin
        left_next   = left_reg;
        halted_next = halted_reg;
        stat.halted = halted_reg;
        stat.push   = 1'b0;
        if (accept)
        begin
            left_next   = left_eff;
            halted_next = halted_eff;
            if (!halted_eff)
            begin
                if (code_point == '0)
                begin
                    halted_next = 1'b1;
                end
                else if (cfg.limit_enable && (BUDGET_WIDTH'(len) > left_eff))
                begin
                    halted_next = 1'b1;
                end
                else
                begin
                    stat.push = 1'b1;
                    if (cfg.limit_enable)
                    begin
                        left_next = left_eff - BUDGET_WIDTH'(len);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            left_reg   <= left_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// ===== sv/u8e_queue.sv =====
// Two-entry queue of encoded characters between the front and back ends.
// Depends on u8e_pkg.
module u8e_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  u8e_pkg::u8e_entry_t        push_entry,
    input  logic                       pop,
    output logic                       full,
    output logic                       not_empty,
    output u8e_pkg::u8e_entry_t        head,
    output logic [u8e_pkg::QCNT_W-1:0] count
);

    u8e_pkg::u8e_entry_t             mem_reg [u8e_pkg::QDEPTH];
    logic [u8e_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [u8e_pkg::QCNT_W-1:0]      count_reg, count_next;

    function automatic logic [u8e_pkg::QCNT_W-1:0] QCNT_W_push(input logic b);
        QCNT_W_push = {{(u8e_pkg::QCNT_W-1){1'b0}}, b};
    endfunction

    assign full      = (count_reg == u8e_pkg::QCNT_W'(u8e_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W_push(push) - QCNT_W_push(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/u8e_back.sv =====
// Back end: sends the bytes of the queue head one beat at a time.
// Depends on u8e_pkg.
module u8e_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  u8e_pkg::u8e_entry_t  head,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [7:0]           out_byte,
    output logic                 char_last,
    output logic                 pop
);

    logic [1:0] idx_reg, idx_next;

    assign out_valid = head_valid;
    assign out_byte  = head.bytes[idx_reg];
    assign char_last = (idx_reg == head.last_idx);
    assign pop       = out_valid && out_ready && char_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (out_valid && out_ready)
        begin
            idx_next = char_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== sv/utf8_encoder_with_byte_budget.sv =====
// Channel    Role    Payload                      Beat
// cfg        sink    index, data                  one register write
// char_in    sink    code_point, string_start     one character
// byte_out   source  out_byte, char_last          one encoded byte
//
// Output carries one byte per cycle while ready is high; a character is one to four bytes.
// The front end takes a new character each cycle while the two-entry queue has room.
// Budget and halt state update in the cycle a character is accepted.
// Reset clears the budget, halt flag, queue and configuration; either side may stall freely.
// Top level of the UTF-8 encoder; depends on u8e_pkg, the interfaces and the sub-modules.
module utf8_encoder_with_byte_budget #(
    parameter int BUDGET_WIDTH = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    u8e_cfg_if.sink  cfg,
    u8e_char_if.sink char_in,
    u8e_byte_if.source byte_out
);

    u8e_pkg::u8e_cfg_t           cfg_reg, cfg_next;
    u8e_pkg::u8e_entry_t         push_entry, head;
    u8e_pkg::u8e_front_stat_t    stat;
    logic                        q_full, q_not_empty, pop;
    logic [u8e_pkg::QCNT_W-1:0]  q_count;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                u8e_pkg::REG_LIMIT_ENABLE: cfg_next.limit_enable = cfg.data[0];
                u8e_pkg::REG_BYTE_BUDGET:  cfg_next.byte_budget  = cfg.data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    u8e_front #(
        .BUDGET_WIDTH (BUDGET_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (char_in.valid),
        .code_point   (char_in.code_point),
        .string_start (char_in.string_start),
        .q_full       (q_full),
        .in_ready     (char_in.ready),
        .push_entry   (push_entry),
        .stat         (stat)
    );

    u8e_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (stat.push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (head),
        .count      (q_count)
    );

    u8e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_not_empty),
        .head       (head),
        .out_ready  (byte_out.ready),
        .out_valid  (byte_out.valid),
        .out_byte   (byte_out.out_byte),
        .char_last  (byte_out.char_last),
        .pop        (pop)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= u8e_pkg::QCNT_W'(u8e_pkg::QDEPTH))
        else $error("queue count beyond its depth");

    a_end_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (char_in.valid && char_in.ready && char_in.code_point == '0) |-> !stat.push)
        else $error("end of string produced bytes");

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.halted && !char_in.string_start) |-> !stat.push)
        else $error("bytes produced while halted");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        stat.push |-> !q_full)
        else $error("push into a full queue");

endmodule

// ===== tb/tb_utf8_encoder_with_byte_budget.sv =====
// Self-checking testbench for utf8_encoder_with_byte_budget.
// A directed table, then random strings under several budget settings, each byte
// checked against the table's bytes or a built-in encoder; depends on u8e_pkg and the channel interfaces.
module tb_utf8_encoder_with_byte_budget;

    localparam int BUDGET_W     = 16;
    localparam int RANDOM_CHARS = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int CP_W         = u8e_pkg::CP_W;
    localparam int CFG_IDX_W    = u8e_pkg::CFG_IDX_W;

    typedef enum logic {ROW_CHAR, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CP_W-1:0]      val;
        logic                 start;
        logic                 typed;
        logic [2:0]           n;
        logic [31:0]          word;
    } stim_row_t;

    typedef struct packed {
        logic        typed;
        logic [2:0]  n;
        logic [31:0] word;
    } char_note_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } enc_byte_t;

    logic clk;
    logic rst_n;

    u8e_cfg_if  cfg();
    u8e_char_if char_in();
    u8e_byte_if byte_out();

    utf8_encoder_with_byte_budget #(.BUDGET_WIDTH(BUDGET_W)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .char_in  (char_in),
        .byte_out (byte_out)
    );

    logic                limit_on    = 1'b0;
    logic [BUDGET_W-1:0] budget_reg  = '0;
    logic [BUDGET_W-1:0] bytes_left  = '0;
    logic                halted      = 1'b0;

    enc_byte_t  expected_bytes[$];
    char_note_t pending_chars[$];

    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    bit calm    = 1'b0;

    int errors        = 0;
    int chars_sent    = 0;
    int live_chars    = 0;
    int bytes_checked = 0;
    int settings      = 0;

    stim_row_t dir_tab [31] = '{
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000024, 1'b0, 1'b1, 3'd1, 32'h24000000},
        '{ROW_REG,  u8e_pkg::REG_LIMIT_ENABLE, 21'd1,      1'b0, 1'b0, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000041, 1'b0, 1'b1, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000042, 1'b0, 1'b1, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000043, 1'b1, 1'b1, 3'd0, 32'h0},
        '{ROW_REG,  u8e_pkg::REG_BYTE_BUDGET,  21'd6,      1'b0, 1'b0, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h00007F, 1'b1, 1'b1, 3'd1, 32'h7F000000},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000080, 1'b0, 1'b1, 3'd2, 32'hC2800000},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000800, 1'b0, 1'b1, 3'd3, 32'hE0A08000},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000041, 1'b0, 1'b1, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000042, 1'b0, 1'b1, 3'd0, 32'h0},
        '{ROW_REG,  u8e_pkg::REG_BYTE_BUDGET,  21'h00FFFF, 1'b0, 1'b0, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h10FFFF, 1'b1, 1'b1, 3'd4, 32'hF48FBFBF},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h1FFFFF, 1'b0, 1'b1, 3'd4, 32'hF7BFBFBF},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000000, 1'b0, 1'b1, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000041, 1'b0, 1'b1, 3'd0, 32'h0},
        '{ROW_REG,  u8e_pkg::REG_LIMIT_ENABLE, 21'd0,      1'b0, 1'b0, 3'd0, 32'h0},
        '{ROW_REG,  u8e_pkg::REG_BYTE_BUDGET,  21'd0,      1'b0, 1'b0, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h0007FF, 1'b1, 1'b1, 3'd2, 32'hDFBF0000},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h00FFFF, 1'b0, 1'b1, 3'd3, 32'hEFBFBF00},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h010000, 1'b0, 1'b1, 3'd4, 32'hF0908080},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h00D800, 1'b0, 1'b0, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000001, 1'b0, 1'b1, 3'd1, 32'h01000000},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000000, 1'b0, 1'b1, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000055, 1'b1, 1'b0, 3'd0, 32'h0},
        '{ROW_REG,  u8e_pkg::REG_LIMIT_ENABLE, 21'd1,      1'b0, 1'b0, 3'd0, 32'h0},
        '{ROW_REG,  u8e_pkg::REG_BYTE_BUDGET,  21'd3,      1'b0, 1'b0, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h010000, 1'b1, 1'b1, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000041, 1'b0, 1'b1, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000800, 1'b1, 1'b0, 3'd0, 32'h0},
        '{ROW_CHAR, u8e_pkg::REG_LIMIT_ENABLE, 21'h000003, 1'b0, 1'b1, 3'd0, 32'h0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #3000000;
        $display("tb: failure");
        $finish;
    end

    // Applies one accepted character to the budget state and returns its bytes,
    // lead byte in the top eight bits of word.
    function automatic void encode_char(input logic [CP_W-1:0] cp, input logic st,
                                        output int n, output logic [31:0] word,
                                        output bit ignored);
        n = 0;
        word = '0;
        ignored = 1'b0;
        if (st)
        begin
            bytes_left = budget_reg;
            halted = 1'b0;
        end
        if (halted)
        begin
            ignored = 1'b1;
            return;
        end
        if (cp == '0)
        begin
            halted = 1'b1;
            return;
        end
        if (cp <= u8e_pkg::MAX_LEN1)
            n = 1;
        else if (cp <= u8e_pkg::MAX_LEN2)
            n = 2;
        else if (cp <= u8e_pkg::MAX_LEN3)
            n = 3;
        else
            n = 4;
        if (limit_on)
        begin
            if (n > bytes_left)
            begin
                halted = 1'b1;
                n = 0;
                return;
            end
            bytes_left = bytes_left - BUDGET_W'(n);
        end
        case (n)
            1: word = {cp[7:0], 24'h0};
            2: word = {u8e_pkg::LEAD2 | {3'b0, cp[10:6]},
                       u8e_pkg::CONT | {2'b0, cp[5:0]}, 16'h0};
            3: word = {u8e_pkg::LEAD3 | {4'b0, cp[15:12]},
                       u8e_pkg::CONT | {2'b0, cp[11:6]},
                       u8e_pkg::CONT | {2'b0, cp[5:0]}, 8'h0};
            default: word = {u8e_pkg::LEAD4 | {5'b0, cp[20:18]},
                             u8e_pkg::CONT | {2'b0, cp[17:12]},
                             u8e_pkg::CONT | {2'b0, cp[11:6]},
                             u8e_pkg::CONT | {2'b0, cp[5:0]}};
        endcase
    endfunction

    always @(posedge clk)
    begin : byte_check
        char_note_t note;
        enc_byte_t  want;
        int         nb;
        logic [31:0] word;
        bit         ignored;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == u8e_pkg::REG_LIMIT_ENABLE)
                    limit_on = cfg.data[0];
                else if (cfg.index == u8e_pkg::REG_BYTE_BUDGET)
                    budget_reg = cfg.data;
            end
            if (char_in.valid && char_in.ready)
            begin
                encode_char(char_in.code_point, char_in.string_start, nb, word, ignored);
                if (!ignored)
                    live_chars++;
                if (pending_chars.size() == 0)
                begin
                    errors++;
                    $display("%0t: character beat expected none actual %h", $time,
                             char_in.code_point);
                end
                else
                begin
                    note = pending_chars.pop_front();
                    if (note.typed)
                    begin
                        nb = int'(note.n);
                        word = note.word;
                    end
                end
                for (int k = 0; k < nb; k++)
                begin
                    want.value = word[31 - 8 * k -: 8];
                    want.last = (k == nb - 1);
                    expected_bytes.push_back(want);
                end
            end
            if (byte_out.valid && byte_out.ready)
            begin
                bytes_checked++;
                if (expected_bytes.size() == 0)
                begin
                    errors++;
                    $display("%0t: byte beat expected none actual %h", $time,
                             byte_out.out_byte);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (byte_out.out_byte !== want.value)
                    begin
                        errors++;
                        $display("%0t: out_byte expected %h actual %h", $time,
                                 want.value, byte_out.out_byte);
                    end
                    if (byte_out.char_last !== want.last)
                    begin
                        errors++;
                        $display("%0t: char_last expected %b actual %b", $time,
                                 want.last, byte_out.char_last);
                    end
                end
            end
        end
    end

    initial
    begin : byte_sink
        byte_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_gaps && !calm && $urandom_range(0, 3) == 0)
            begin
                byte_out.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            byte_out.ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_char(input logic [CP_W-1:0] cp, input logic st, input logic typed,
                             input logic [2:0] n, input logic [31:0] word);
        char_note_t note;
        cfg.valid <= 1'b0;
        if (tx_gaps && !calm && $urandom_range(0, 3) == 0)
        begin
            char_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        note.typed = typed;
        note.n = n;
        note.word = word;
        pending_chars.push_back(note);
        char_in.valid <= 1'b1;
        char_in.code_point <= cp;
        char_in.string_start <= st;
        do
            @(posedge clk);
        while (char_in.ready !== 1'b1);
        chars_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
    endtask

    // Waits for every expected byte, then lets the block go quiet.
    task automatic settle();
        int waited;
        char_in.valid <= 1'b0;
        cfg.valid <= 1'b0;
        waited = 0;
        while ((expected_bytes.size() != 0 || pending_chars.size() != 0) && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_bytes.size() != 0 || pending_chars.size() != 0)
        begin
            errors++;
            $display("%0t: bytes outstanding expected 0 actual %0d", $time,
                     expected_bytes.size());
            expected_bytes.delete();
            pending_chars.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CP_W-1:0] pick_code_point();
        case ($urandom_range(0, 9))
            0, 1, 2: return CP_W'($urandom_range(1, 32'h7F));
            3, 4:    return CP_W'($urandom_range(32'h80, 32'h7FF));
            5, 6:    return CP_W'($urandom_range(32'h800, 32'hFFFF));
            7, 8:    return CP_W'($urandom_range(32'h10000, 32'h10FFFF));
            default: return CP_W'($urandom_range(32'h110000, 32'h1FFFFF));
        endcase
    endfunction

    task automatic send_string();
        int len;
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++)
            send_char(pick_code_point(), k == 0, 1'b0, 3'd0, 32'h0);
        if ($urandom_range(0, 3) != 0)
            send_char('0, 1'b0, 1'b0, 3'd0, 32'h0);
    endtask

    task automatic send_noise();
        logic [CP_W-1:0] cp;
        cp = ($urandom_range(0, 3) == 0) ? '0 : CP_W'($urandom);
        send_char(cp, 1'($urandom_range(0, 1)), 1'b0, 3'd0, 32'h0);
    endtask

    initial
    begin : stimulus
        int          base;
        int          phase;
        int          phase_end;
        logic        en;
        logic [15:0] bud;
        rst_n <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        char_in.valid <= 1'b0;
        char_in.code_point <= '0;
        char_in.string_start <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < 31; r++)
        begin
            if (dir_tab[r].kind == ROW_REG)
            begin
                settle();
                write_reg(dir_tab[r].idx, dir_tab[r].val[15:0]);
            end
            else
                send_char(dir_tab[r].val, dir_tab[r].start, dir_tab[r].typed,
                          dir_tab[r].n, dir_tab[r].word);
        end

        base = chars_sent;
        phase = 0;
        while (chars_sent - base < RANDOM_CHARS)
        begin
            settle();
            case (phase % 6)
                0: begin en = 1'b1; bud = 16'h0000; end
                1: begin en = 1'b1; bud = 16'hFFFF; end
                2: begin en = 1'b0; bud = 16'($urandom); end
                3: begin en = 1'b1; bud = 16'($urandom_range(1, 16)); end
                4: begin en = 1'b1; bud = 16'($urandom_range(17, 60)); end
                default: begin en = 1'($urandom_range(0, 1)); bud = 16'($urandom); end
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(u8e_pkg::REG_LIMIT_ENABLE, {15'b0, en});
                write_reg(u8e_pkg::REG_BYTE_BUDGET, bud);
            end
            else
            begin
                write_reg(u8e_pkg::REG_BYTE_BUDGET, bud);
                write_reg(u8e_pkg::REG_LIMIT_ENABLE, {15'b0, en});
            end
            settings++;
            tx_gaps = ($urandom_range(0, 2) != 0);
            rx_gaps = ($urandom_range(0, 2) != 0);
            phase_end = chars_sent + ((phase % 6 == 0) ? 8 : $urandom_range(35, 60));
            while (chars_sent < phase_end && chars_sent - base < RANDOM_CHARS)
            begin
                calm = (chars_sent - base >= RANDOM_CHARS - 60);
                if ($urandom_range(0, 4) != 0)
                    send_string();
                else
                    send_noise();
            end
            phase++;
        end
        settle();

        $display("Run covered %0d characters, %0d of them acted upon, and %0d bytes,",
                 chars_sent, live_chars, bytes_checked);
        $display("over the directed table and %0d random budget settings.", settings);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== utf8_encoder_with_byte_budget.f =====
sv/u8e_pkg.sv
sv/u8e_ifs.sv
sv/u8e_front.sv
sv/u8e_queue.sv
sv/u8e_back.sv
sv/utf8_encoder_with_byte_budget.sv
tb/tb_utf8_encoder_with_byte_budget.sv
